>>> rtl/core/vlc_pkg.sv
package vlc_pkg;

	localparam int unsigned CMD_W  = 2;
	localparam int unsigned PAGE_W = 32;
	localparam int unsigned REV_W  = 64;
	localparam int unsigned PAY_W  = 32;
	localparam int unsigned OCC_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_PUT    = 2'd1,
		CMD_EVICT  = 2'd2
	} cmd_e_t;

	// Row operations applied by every cell in the same cycle.
	typedef enum logic [1:0] {
		SH_HOLD    = 2'd0,
		SH_PROMOTE = 2'd1,
		SH_ALL     = 2'd2,
		SH_UP      = 2'd3
	} shift_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
		logic [REV_W-1:0]  revision;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	typedef struct packed {
		logic             tok;
		logic             found;
		logic             revok;
		logic [PAY_W-1:0] payload;
	} scan_t;

	typedef struct packed {
		shift_op_t         op;
		logic [PAGE_W-1:0] page;
		logic [REV_W-1:0]  revision;
	} ctl_t;

endpackage

>>> rtl/core/vlc_if.sv
interface vlc_req_if;
	import vlc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [PAGE_W-1:0] page_id;
	logic [REV_W-1:0]  revision;
	logic [PAY_W-1:0]  payload_handle;

	modport source (output valid, command, page_id, revision, payload_handle, input ready);
	modport sink (input valid, command, page_id, revision, payload_handle, output ready);
endinterface

interface vlc_rsp_if;
	import vlc_pkg::*;

	logic             valid;
	logic             ready;
	logic             hit;
	logic [PAY_W-1:0] payload_out;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, hit, payload_out, occupancy, input ready);
	modport sink (input valid, hit, payload_out, occupancy, output ready);
endinterface

>>> rtl/core/vlc_cell.sv
module vlc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  vlc_pkg::ctl_t   ctl,
	input  vlc_pkg::entry_t left,
	input  vlc_pkg::entry_t right,
	input  logic            earlier,
	input  vlc_pkg::scan_t  scan_in,
	output vlc_pkg::entry_t entry,
	output vlc_pkg::scan_t  scan_out,
	output logic            incl
);
	import vlc_pkg::*;

	logic              valid_q;
	logic [PAGE_W-1:0] page_q;
	logic [REV_W-1:0]  rev_q;
	logic [PAY_W-1:0]  pay_q;
	logic              incl_q;
	logic              tok_q;
	logic              found_q;
	logic              revok_q;
	logic [PAY_W-1:0]  scan_pay_q;
	logic              match;
	logic              revok;
	logic              take_left;
	logic              take_right;
	entry_t            next_ent;

	assign match = valid_q && (page_q == ctl.page);
	assign revok = (rev_q == ctl.revision);

	// Cells up to and including the matching one move one place toward
	// the tail on a promote; cells from the match on move toward the head
	// when an entry is removed.
	always_comb begin
		take_left  = 1'b0;
		take_right = 1'b0;
		case (ctl.op)
			SH_PROMOTE: take_left  = !earlier;
			SH_ALL:     take_left  = 1'b1;
			SH_UP:      take_right = incl_q;
			default:    ;
		endcase
		next_ent = take_left ? left : right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			incl_q  <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= scan_in.tok;
			if (scan_in.tok) begin
				incl_q <= scan_in.found || match;
			end
			if (take_left || take_right) begin
				valid_q <= next_ent.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.tok) begin
			found_q    <= scan_in.found || match;
			revok_q    <= match ? revok : scan_in.revok;
			scan_pay_q <= match ? pay_q : scan_in.payload;
		end
		if (take_left || take_right) begin
			page_q <= next_ent.page;
			rev_q  <= next_ent.revision;
			pay_q  <= next_ent.payload;
		end
	end

	assign entry    = '{valid: valid_q, page: page_q, revision: rev_q, payload: pay_q};
	assign scan_out = '{tok: tok_q, found: found_q, revok: revok_q, payload: scan_pay_q};
	assign incl     = incl_q;

endmodule

>>> rtl/core/versioned_lru_cache.sv
// Versioned LRU cache of page payload handles.
// Requests arrive on the req channel (command, page_id, revision,
// payload_handle); one result per request leaves on the rsp channel
// (hit, payload_out, occupancy). A transfer happens when valid and ready
// are both high at a rising clock edge.
// Entries sit in a row of cells kept in recency order, most recent in
// cell 0, with valid entries packed at the head of the row. A scan token
// walks the row one cell per cycle to find the page, then the whole row
// shifts by one place, all cells together, to promote, insert or remove.
// The result of a request is registered once the scan token has walked
// across the whole row.
// The block takes one request at a time: a new request is taken only
// after the last one has committed its update; req.ready is high while it is
// idle, also while an earlier result still waits in the output register.
// If the receiver stalls, the finished request waits until the output
// register frees and only then commits its update to the row.
// Reset (arst_n low) empties the cache and drops any pending result.
module versioned_lru_cache #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	vlc_req_if.sink   req,
	vlc_rsp_if.source rsp
);
	import vlc_pkg::*;

	localparam int unsigned CW = $clog2(ENTRIES + 1);

	state_t            state_q;
	state_t            state_d;
	cmd_e_t            cmd_q;
	logic [PAGE_W-1:0] page_q;
	logic [REV_W-1:0]  rev_q;
	logic [PAY_W-1:0]  handle_q;
	logic              tok0_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic              out_valid_q;
	logic              hit_q;
	logic [PAY_W-1:0]  pay_out_q;
	logic [OCC_W-1:0]  occ_q;

	logic              accept;
	logic              fire;
	logic              hit_d;
	logic [PAY_W-1:0]  pay_d;
	shift_op_t         op_d;
	ctl_t              ctl;
	entry_t            insert;
	entry_t            ents [ENTRIES];
	scan_t             chain [ENTRIES+1];
	logic [ENTRIES-1:0] incl_vec;
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES:0]   tok_vec;
	scan_t             scan_end;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign fire      = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign scan_end  = chain[ENTRIES];

	assign chain[0] = '{tok: tok0_q, found: 1'b0, revok: 1'b0, payload: '0};

	always_comb begin
		insert.valid    = 1'b1;
		insert.page     = page_q;
		insert.revision = rev_q;
		insert.payload  = (cmd_q == CMD_PUT) ? handle_q : scan_end.payload;
	end

	always_comb begin
		hit_d   = 1'b0;
		pay_d   = '0;
		op_d    = SH_HOLD;
		count_d = count_q;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (scan_end.found && scan_end.revok) begin
					hit_d = 1'b1;
					pay_d = scan_end.payload;
					op_d  = SH_PROMOTE;
				end
			end
			CMD_PUT: begin
				if (scan_end.found) begin
					op_d = SH_PROMOTE;
				end else begin
					// The oldest entry falls off the tail when the row is full.
					op_d = SH_ALL;
					if (count_q != CW'(ENTRIES)) begin
						count_d = count_q + CW'(1);
					end
				end
			end
			CMD_EVICT: begin
				if (scan_end.found) begin
					hit_d   = 1'b1;
					op_d    = SH_UP;
					count_d = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign ctl = '{op: fire ? op_d : SH_HOLD, page: page_q, revision: rev_q};

	generate
		for (genvar k = 0; k < ENTRIES; k++) begin : g_row
			entry_t left_ent;
			entry_t right_ent;
			logic   earlier_k;

			if (k == 0) begin : g_head
				assign left_ent  = insert;
				assign earlier_k = 1'b0;
			end else begin : g_mid
				assign left_ent  = ents[k-1];
				assign earlier_k = incl_vec[k-1];
			end
			if (k == ENTRIES - 1) begin : g_tail
				assign right_ent = '0;
			end else begin : g_body
				assign right_ent = ents[k+1];
			end

			vlc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.left     (left_ent),
				.right    (right_ent),
				.earlier  (earlier_k),
				.scan_in  (chain[k]),
				.entry    (ents[k]),
				.scan_out (chain[k+1]),
				.incl     (incl_vec[k])
			);

			assign valid_vec[k] = ents[k].valid;
		end
		for (genvar j = 0; j <= ENTRIES; j++) begin : g_tok
			assign tok_vec[j] = chain[j].tok;
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end.tok) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tok0_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tok0_q  <= accept;
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_e_t'(req.command);
			page_q   <= req.page_id;
			rev_q    <= req.revision;
			handle_q <= req.payload_handle;
		end
		if (fire) begin
			hit_q     <= hit_d;
			pay_out_q <= pay_d;
			occ_q     <= OCC_W'(count_d);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.payload_out = pay_out_q;
	assign rsp.occupancy   = occ_q;

`ifndef NO_ASSERTIONS
	a_packed_row: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid entries are not packed at the head of the row");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_vec)))
		else $error("occupancy counter disagrees with the valid entries");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan token in the row");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end.tok |-> state_q == ST_SCAN)
		else $error("scan token left the row outside a scan");

	a_row_still: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DONE) |=> $stable(valid_vec))
		else $error("row changed outside the commit of a request");
`endif

endmodule

>>> test/versioned_lru_cache_tb.sv
`timescale 1ns / 1ps

module versioned_lru_cache_tb;
	import vlc_pkg::*;

	localparam int unsigned ENTRIES      = 16;
	localparam int unsigned POOL_SIZE    = 32;
	localparam int unsigned RANDOM_ITEMS = 1830;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [PAGE_W-1:0] page_id;
		logic [REV_W-1:0]  revision;
		logic [PAY_W-1:0]  payload_handle;
	} cache_req_t;

	typedef struct packed {
		logic             hit;
		logic [PAY_W-1:0] payload_out;
		logic [OCC_W-1:0] occupancy;
	} cache_reply_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [REV_W-1:0]  revision;
		logic [PAY_W-1:0]  payload;
	} lru_line_t;

	logic clk;
	logic arst_n;

	vlc_req_if req_ch ();
	vlc_rsp_if rsp_ch ();

	versioned_lru_cache #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow of the cache contents, most recently used line at the front.
	lru_line_t    lru_lines[$];
	cache_req_t   request_backlog[$];
	cache_reply_t replies_due[$];

	logic [PAGE_W-1:0] page_pool[POOL_SIZE];
	logic [REV_W-1:0]  rev_pool[POOL_SIZE];

	int unsigned cycle_count = 0;
	int          error_count = 0;
	logic        req_taken   = 1'b0;
	int          req_gap     = 0;
	int          req_quiet   = 0;
	int          rsp_stall   = 0;
	int          rsp_quiet   = 0;
	cache_req_t  next_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic cache_reply_t predict_cache_reply(input cache_req_t rq);
		cache_reply_t res;
		lru_line_t    line;
		int           idx;
		int           i;
		res = '0;
		idx = -1;
		for (i = 0; i < lru_lines.size(); i++) begin
			if (lru_lines[i].page == rq.page_id) idx = i;
		end
		case (rq.command)
			CMD_LOOKUP: begin
				if (idx >= 0 && lru_lines[idx].revision == rq.revision) begin
					line = lru_lines[idx];
					lru_lines.delete(idx);
					lru_lines.insert(0, line);
					res.hit = 1'b1;
					res.payload_out = line.payload;
				end
			end
			CMD_PUT: begin
				if (idx >= 0) lru_lines.delete(idx);
				while (lru_lines.size() >= ENTRIES) lru_lines.delete(lru_lines.size() - 1);
				line.page = rq.page_id;
				line.revision = rq.revision;
				line.payload = rq.payload_handle;
				lru_lines.insert(0, line);
			end
			CMD_EVICT: begin
				if (idx >= 0) begin
					lru_lines.delete(idx);
					res.hit = 1'b1;
				end
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(lru_lines.size());
		return res;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a quiet stretch with none.
	function automatic int draw_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 99) < 3) quiet = $urandom_range(20, 60);
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page,
			input logic [REV_W-1:0] rev, input logic [PAY_W-1:0] handle);
		cache_req_t rq;
		rq.command = cmd;
		rq.page_id = page;
		rq.revision = rev;
		rq.payload_handle = handle;
		request_backlog.insert(request_backlog.size(), rq);
	endtask

	// Request driver: holds an item until its transfer, then waits out a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!(req_ch.valid && !req_taken)) begin
			if (req_gap > 0) begin
				req_ch.valid <= 1'b0;
				req_gap--;
			end else if (request_backlog.size() > 0) begin
				next_req = request_backlog.pop_front();
				req_ch.command <= next_req.command;
				req_ch.page_id <= next_req.page_id;
				req_ch.revision <= next_req.revision;
				req_ch.payload_handle <= next_req.payload_handle;
				req_ch.valid <= 1'b1;
				req_gap = draw_gap(req_quiet);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 99) < 20) rsp_stall = draw_gap(rsp_quiet);
		end
	end

	// Monitor: checks each result transfer, then predicts from each request transfer.
	always @(posedge clk) begin
		cache_reply_t exp_reply;
		cache_req_t   rq;
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result: hit %0d payload_out %h occupancy %0d",
					rsp_ch.hit, rsp_ch.payload_out, rsp_ch.occupancy);
				error_count++;
			end else begin
				exp_reply = replies_due.pop_front();
				if (rsp_ch.hit !== exp_reply.hit) begin
					$error("hit: expected %0d, got %0d", exp_reply.hit, rsp_ch.hit);
					error_count++;
				end
				if (rsp_ch.payload_out !== exp_reply.payload_out) begin
					$error("payload_out: expected %h, got %h", exp_reply.payload_out,
						rsp_ch.payload_out);
					error_count++;
				end
				if (rsp_ch.occupancy !== exp_reply.occupancy) begin
					$error("occupancy: expected %0d, got %0d", exp_reply.occupancy,
						rsp_ch.occupancy);
					error_count++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			rq.command = req_ch.command;
			rq.page_id = req_ch.page_id;
			rq.revision = req_ch.revision;
			rq.payload_handle = req_ch.payload_handle;
			replies_due.insert(replies_due.size(), predict_cache_reply(rq));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int                n;
		int                r;
		int                pidx;
		int                pool_hi;
		logic [PAGE_W-1:0] pg;
		logic [REV_W-1:0]  rev;
		logic [PAY_W-1:0]  handle;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = '0;
		req_ch.page_id = '0;
		req_ch.revision = '0;
		req_ch.payload_handle = '0;
		rsp_ch.ready = 1'b0;

		// Directed: empty cache, field extremes, replacement, revision mismatch,
		// eviction of present and absent pages, and the unused command.
		queue_request(CMD_LOOKUP, 32'h0, 64'h0, 32'h0);
		queue_request(CMD_EVICT, 32'hFFFF_FFFF, 64'h0, 32'h0);
		queue_request(CMD_PUT, 32'h0, 64'h0, 32'hFFFF_FFFF);
		queue_request(CMD_PUT, 32'hFFFF_FFFF, '1, 32'h0);
		queue_request(CMD_LOOKUP, 32'h0, 64'h0, 32'h0);
		queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF);
		queue_request(CMD_LOOKUP, 32'h0, 64'h1, 32'h0);
		queue_request(CMD_PUT, 32'h0, 64'h8000_0000_0000_0000, 32'h1234_5678);
		queue_request(CMD_LOOKUP, 32'h0, 64'h0, 32'h0);
		queue_request(CMD_LOOKUP, 32'h0, 64'h8000_0000_0000_0000, 32'h0);
		queue_request(CMD_UNUSED, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF);
		queue_request(CMD_EVICT, 32'h0, 64'h0, 32'h0);
		queue_request(CMD_EVICT, 32'h0, 64'h0, 32'h0);
		queue_request(CMD_LOOKUP, 32'h0, 64'h8000_0000_0000_0000, 32'h0);
		queue_request(CMD_PUT, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 32'h5A5A_5A5A);
		queue_request(CMD_LOOKUP, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5B, 32'h0);
		queue_request(CMD_LOOKUP, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 32'h0);

		for (n = 0; n < POOL_SIZE; n++) begin
			page_pool[n] = $urandom;
			rev_pool[n] = {$urandom, $urandom};
		end
		page_pool[0] = 32'h0;
		page_pool[1] = 32'hFFFF_FFFF;

		// Pages come from a pool whose active size changes per phase, so that the
		// cache sometimes fits the working set and sometimes keeps evicting.
		pool_hi = POOL_SIZE - 1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				case ($urandom_range(0, 4))
					0: pool_hi = 5;
					1: pool_hi = 11;
					2: pool_hi = 17;
					3: pool_hi = 23;
					default: pool_hi = POOL_SIZE - 1;
				endcase
			end
			if ($urandom_range(0, 49) == 0) page_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
			pidx = $urandom_range(0, pool_hi);
			pg = ($urandom_range(0, 19) == 0) ? $urandom : page_pool[pidx];
			rev = {$urandom, $urandom};
			handle = $urandom;
			r = $urandom_range(0, 99);
			if (r < 45) begin
				if ($urandom_range(0, 3) != 0) rev = rev_pool[pidx];
				else if ($urandom_range(0, 1) == 1)
					rev = rev_pool[pidx] ^ (64'd1 << $urandom_range(0, 63));
				queue_request(CMD_LOOKUP, pg, rev, handle);
			end else if (r < 80) begin
				if ($urandom_range(0, 3) == 0) rev = rev_pool[pidx];
				else if ($urandom_range(0, 15) == 0) rev = $urandom_range(0, 1) ? '1 : '0;
				if ($urandom_range(0, 15) == 0) handle = $urandom_range(0, 1) ? '1 : '0;
				rev_pool[pidx] = rev;
				queue_request(CMD_PUT, pg, rev, handle);
			end else if (r < 95) begin
				queue_request(CMD_EVICT, pg, rev, handle);
			end else begin
				queue_request(CMD_UNUSED, pg, rev, handle);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() > 0 || req_ch.valid) @(posedge clk);
		while (replies_due.size() > 0) @(posedge clk);
		repeat (3 * ENTRIES) @(posedge clk);

		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
